// ===== hdl/dmpv_pkg.sv =====
`timescale 1ns / 1ps

package dmpv_pkg;

  localparam int GAIN_W = 24;
  localparam int BAND_W = 15;
  localparam int ERR_W  = 16;
  localparam int CMD_W  = 16;
  localparam int FUNC_W = 2;
  localparam int IDX_W  = 3;

  // Gain (unsigned, one extra sign bit) times a Q12.4 value.
  localparam int PROD_W = GAIN_W + 1 + ERR_W;
  localparam int SUM_W  = PROD_W + 1;
  localparam int FRAC_SHIFT = 14;
  localparam int RND_W  = SUM_W - FRAC_SHIFT;

  localparam logic [FUNC_W-1:0] FUNC_COARSE = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_FINE   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd2;

  localparam logic [IDX_W-1:0] REG_COARSE_LIN_GAIN = 3'd0;
  localparam logic [IDX_W-1:0] REG_COARSE_ANG_GAIN = 3'd1;
  localparam logic [IDX_W-1:0] REG_FINE_LIN_GAIN   = 3'd2;
  localparam logic [IDX_W-1:0] REG_FINE_ANG_GAIN   = 3'd3;
  localparam logic [IDX_W-1:0] REG_FINE_LIN_IGAIN  = 3'd4;
  localparam logic [IDX_W-1:0] REG_FINE_ANG_IGAIN  = 3'd5;
  localparam logic [IDX_W-1:0] REG_DIST_DEADBAND   = 3'd6;
  localparam logic [IDX_W-1:0] REG_ANGLE_DEADBAND  = 3'd7;

  localparam logic [GAIN_W-1:0] RST_COARSE_LIN_GAIN = 24'd10905;
  localparam logic [GAIN_W-1:0] RST_COARSE_ANG_GAIN = 24'd109052;
  localparam logic [GAIN_W-1:0] RST_FINE_LIN_GAIN   = 24'd13422;
  localparam logic [GAIN_W-1:0] RST_FINE_ANG_GAIN   = 24'd1342177;
  localparam logic [GAIN_W-1:0] RST_FINE_LIN_IGAIN  = 24'd24327;
  localparam logic [GAIN_W-1:0] RST_FINE_ANG_IGAIN  = 24'd83886;

  // Integrator clamp, +-25.0 in Q12.4.
  localparam logic signed [ERR_W-1:0] INT_LIMIT = 16'sd400;

  // Output limits in Q2.14.
  localparam logic [CMD_W-1:0] COARSE_ANG_MAX = 16'd8192;
  localparam logic [CMD_W-1:0] COARSE_LIN_MAX = 16'd2458;
  localparam logic [CMD_W-1:0] FINE_ANG_MAX   = 16'd2458;
  localparam logic [CMD_W-1:0] FINE_LIN_MAX   = 16'd819;

  typedef struct packed {
    logic [GAIN_W-1:0] coarse_lin_gain;
    logic [GAIN_W-1:0] coarse_ang_gain;
    logic [GAIN_W-1:0] fine_lin_gain;
    logic [GAIN_W-1:0] fine_ang_gain;
    logic [GAIN_W-1:0] fine_lin_igain;
    logic [GAIN_W-1:0] fine_ang_igain;
    logic [BAND_W-1:0] dist_deadband;
    logic [BAND_W-1:0] angle_deadband;
  } dmpv_cfg_t;

  // active: the word drives the outputs; fine: PI gains and fine limits apply.
  typedef struct packed {
    logic active;
    logic fine;
  } dmpv_ctl_t;

endpackage

// ===== hdl/dual_mode_pi_velocity_controller.sv =====
`timescale 1ns / 1ps

// Dual-mode PI velocity controller.
// Input channel (in_valid/in_ready) takes one word per cycle while not stalled: a
// mode code, the goal-seen flag and two Q12.4 errors. Each word yields exactly
// one result word (out_valid/out_ready) carrying the saturated Q2.14 linear and
// angular commands; coarse, clear and unused-mode words still produce a result
// (zero where the mode gives no drive).
// The word is caught in the input register at acceptance, then passes the product
// register (four 25x16 multipliers) and the round/saturate output register.
// Throughput is one word per cycle unless the receiver stalls; the integrators are
// updated in the accept cycle with one add and clamp, so back-to-back fine words
// see each other. A stalled receiver holds the output register; the two earlier
// stages keep filling, so up to three words sit in the pipe before in_ready drops.
// Synchronous reset empties the pipe, zeroes both integrators and loads the
// default gains and zero deadbands. The cfg_ port writes one register per
// cycle and should be used only while no word is in flight.
module dual_mode_pi_velocity_controller (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [dmpv_pkg::IDX_W-1:0]           cfg_index,
  input  logic [dmpv_pkg::GAIN_W-1:0]          cfg_wdata,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [dmpv_pkg::FUNC_W-1:0]          in_func,
  input  logic                                 in_goal_seen,
  input  logic signed [dmpv_pkg::ERR_W-1:0]    in_dist_error,
  input  logic signed [dmpv_pkg::ERR_W-1:0]    in_angle_error,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [dmpv_pkg::CMD_W-1:0]    out_linear_cmd,
  output logic signed [dmpv_pkg::CMD_W-1:0]    out_angular_cmd
);
  import dmpv_pkg::*;

  dmpv_cfg_t cfg;

  logic accept;
  logic s1_adv;
  logic s2_adv;
  logic out_adv;

  logic s1_valid_r;
  logic s2_valid_r;
  logic out_valid_r;

  dmpv_ctl_t ctl_nxt;
  dmpv_ctl_t s1_ctl_r;
  logic signed [ERR_W-1:0] s1_de_r;
  logic signed [ERR_W-1:0] s1_ae_r;
  logic signed [ERR_W-1:0] s1_di_r;
  logic signed [ERR_W-1:0] s1_ai_r;

  logic signed [ERR_W-1:0] dist_integ_nxt;
  logic signed [ERR_W-1:0] angle_integ_nxt;
  logic signed [ERR_W-1:0] dist_integ_q;
  logic signed [ERR_W-1:0] angle_integ_q;

  dmpv_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg_q     (cfg)
  );

  // Each stage moves when the stage after it is empty or moving too.
  assign out_adv  = s2_valid_r && (!out_valid_r || out_ready);
  assign s1_adv   = s1_valid_r && (!s2_valid_r || out_adv);
  assign s2_adv   = s1_adv;
  assign in_ready = !s1_valid_r || s1_adv;
  assign accept   = in_valid && in_ready;

  dmpv_integ u_integ (
    .clk             (clk),
    .rst_n           (rst_n),
    .accept          (accept),
    .func            (in_func),
    .dist_error      (in_dist_error),
    .angle_error     (in_angle_error),
    .dist_integ_nxt  (dist_integ_nxt),
    .angle_integ_nxt (angle_integ_nxt),
    .dist_integ_q    (dist_integ_q),
    .angle_integ_q   (angle_integ_q)
  );

  always_comb begin
    ctl_nxt.fine   = (in_func == FUNC_FINE);
    ctl_nxt.active = (in_func == FUNC_FINE) || ((in_func == FUNC_COARSE) && in_goal_seen);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s2_adv) begin
        s2_valid_r <= 1'b1;
      end else if (out_adv) begin
        s2_valid_r <= 1'b0;
      end
      if (out_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_ctl_r <= ctl_nxt;
      s1_de_r  <= in_dist_error;
      s1_ae_r  <= in_angle_error;
      s1_di_r  <= dist_integ_nxt;
      s1_ai_r  <= angle_integ_nxt;
    end
  end

  dmpv_axis u_lin (
    .clk         (clk),
    .prod_en     (s2_adv),
    .out_en      (out_adv),
    .ctl         (s1_ctl_r),
    .err         (s1_de_r),
    .integ       (s1_di_r),
    .band        (cfg.dist_deadband),
    .coarse_gain (cfg.coarse_lin_gain),
    .fine_gain   (cfg.fine_lin_gain),
    .fine_igain  (cfg.fine_lin_igain),
    .coarse_lim  (COARSE_LIN_MAX),
    .fine_lim    (FINE_LIN_MAX),
    .kill_small  (1'b0),
    .cmd         (out_linear_cmd)
  );

  dmpv_axis u_ang (
    .clk         (clk),
    .prod_en     (s2_adv),
    .out_en      (out_adv),
    .ctl         (s1_ctl_r),
    .err         (s1_ae_r),
    .integ       (s1_ai_r),
    .band        (cfg.angle_deadband),
    .coarse_gain (cfg.coarse_ang_gain),
    .fine_gain   (cfg.fine_ang_gain),
    .fine_igain  (cfg.fine_ang_igain),
    .coarse_lim  (COARSE_ANG_MAX),
    .fine_lim    (FINE_ANG_MAX),
    .kill_small  (1'b1),
    .cmd         (out_angular_cmd)
  );

  assign out_valid = out_valid_r;

  a_clear_zeroes_integ: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_func == FUNC_CLEAR) |=> (dist_integ_q == '0 && angle_integ_q == '0))
    else $error("integrators not cleared after a clear word");

  a_integ_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (dist_integ_q <= INT_LIMIT && dist_integ_q >= -INT_LIMIT &&
     angle_integ_q <= INT_LIMIT && angle_integ_q >= -INT_LIMIT))
    else $error("integrator outside its clamp");

  a_out_within_limits: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_linear_cmd <= $signed(COARSE_LIN_MAX) &&
                   out_linear_cmd >= -$signed(COARSE_LIN_MAX) &&
                   out_angular_cmd <= $signed(COARSE_ANG_MAX) &&
                   out_angular_cmd >= -$signed(COARSE_ANG_MAX)))
    else $error("command beyond the widest saturation limit");

  a_no_unit_angular: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_angular_cmd != 16'sd1 && out_angular_cmd != -16'sd1))
    else $error("angular command of one LSB was not zeroed");

  a_pipe_not_overfull: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s2_valid_r && out_valid_r && !out_ready) |-> !in_ready)
    else $error("input taken while every stage is held");

endmodule

// ===== hdl/dmpv_cfg.sv =====
`timescale 1ns / 1ps

module dmpv_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [dmpv_pkg::IDX_W-1:0]    cfg_index,
  input  logic [dmpv_pkg::GAIN_W-1:0]   cfg_wdata,
  output dmpv_pkg::dmpv_cfg_t           cfg_q
);
  import dmpv_pkg::*;

  dmpv_cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.coarse_lin_gain <= RST_COARSE_LIN_GAIN;
      cfg_r.coarse_ang_gain <= RST_COARSE_ANG_GAIN;
      cfg_r.fine_lin_gain   <= RST_FINE_LIN_GAIN;
      cfg_r.fine_ang_gain   <= RST_FINE_ANG_GAIN;
      cfg_r.fine_lin_igain  <= RST_FINE_LIN_IGAIN;
      cfg_r.fine_ang_igain  <= RST_FINE_ANG_IGAIN;
      cfg_r.dist_deadband   <= '0;
      cfg_r.angle_deadband  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_COARSE_LIN_GAIN: cfg_r.coarse_lin_gain <= cfg_wdata;
        REG_COARSE_ANG_GAIN: cfg_r.coarse_ang_gain <= cfg_wdata;
        REG_FINE_LIN_GAIN:   cfg_r.fine_lin_gain   <= cfg_wdata;
        REG_FINE_ANG_GAIN:   cfg_r.fine_ang_gain   <= cfg_wdata;
        REG_FINE_LIN_IGAIN:  cfg_r.fine_lin_igain  <= cfg_wdata;
        REG_FINE_ANG_IGAIN:  cfg_r.fine_ang_igain  <= cfg_wdata;
        REG_DIST_DEADBAND:   cfg_r.dist_deadband   <= cfg_wdata[BAND_W-1:0];
        REG_ANGLE_DEADBAND:  cfg_r.angle_deadband  <= cfg_wdata[BAND_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_q = cfg_r;

endmodule

// ===== hdl/dmpv_integ.sv =====
`timescale 1ns / 1ps

module dmpv_integ (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 accept,
  input  logic [dmpv_pkg::FUNC_W-1:0]          func,
  input  logic signed [dmpv_pkg::ERR_W-1:0]    dist_error,
  input  logic signed [dmpv_pkg::ERR_W-1:0]    angle_error,
  output logic signed [dmpv_pkg::ERR_W-1:0]    dist_integ_nxt,
  output logic signed [dmpv_pkg::ERR_W-1:0]    angle_integ_nxt,
  output logic signed [dmpv_pkg::ERR_W-1:0]    dist_integ_q,
  output logic signed [dmpv_pkg::ERR_W-1:0]    angle_integ_q
);
  import dmpv_pkg::*;

  logic signed [ERR_W-1:0] dist_integ_r;
  logic signed [ERR_W-1:0] angle_integ_r;

  function automatic logic signed [ERR_W-1:0] clamp_add(
    input logic signed [ERR_W-1:0] acc,
    input logic signed [ERR_W-1:0] err
  );
    logic signed [ERR_W:0] s;
    logic signed [ERR_W:0] lim;
    begin
      s   = {acc[ERR_W-1], acc} + {err[ERR_W-1], err};
      lim = {INT_LIMIT[ERR_W-1], INT_LIMIT};
      if (s > lim) begin
        clamp_add = INT_LIMIT;
      end else if (s < -lim) begin
        clamp_add = -INT_LIMIT;
      end else begin
        clamp_add = s[ERR_W-1:0];
      end
    end
  endfunction

  // The fine word sees the integrator after its own error has been added.
  always_comb begin
    dist_integ_nxt  = dist_integ_r;
    angle_integ_nxt = angle_integ_r;
    unique case (func)
      FUNC_FINE: begin
        dist_integ_nxt  = clamp_add(dist_integ_r, dist_error);
        angle_integ_nxt = clamp_add(angle_integ_r, angle_error);
      end
      FUNC_CLEAR: begin
        dist_integ_nxt  = '0;
        angle_integ_nxt = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dist_integ_r  <= '0;
      angle_integ_r <= '0;
    end else if (accept) begin
      dist_integ_r  <= dist_integ_nxt;
      angle_integ_r <= angle_integ_nxt;
    end
  end

  assign dist_integ_q  = dist_integ_r;
  assign angle_integ_q = angle_integ_r;

endmodule

// ===== hdl/dmpv_axis.sv =====
`timescale 1ns / 1ps

module dmpv_axis (
  input  logic                                 clk,
  input  logic                                 prod_en,
  input  logic                                 out_en,
  input  dmpv_pkg::dmpv_ctl_t                  ctl,
  input  logic signed [dmpv_pkg::ERR_W-1:0]    err,
  input  logic signed [dmpv_pkg::ERR_W-1:0]    integ,
  input  logic [dmpv_pkg::BAND_W-1:0]          band,
  input  logic [dmpv_pkg::GAIN_W-1:0]          coarse_gain,
  input  logic [dmpv_pkg::GAIN_W-1:0]          fine_gain,
  input  logic [dmpv_pkg::GAIN_W-1:0]          fine_igain,
  input  logic [dmpv_pkg::CMD_W-1:0]           coarse_lim,
  input  logic [dmpv_pkg::CMD_W-1:0]           fine_lim,
  input  logic                                 kill_small,
  output logic signed [dmpv_pkg::CMD_W-1:0]    cmd
);
  import dmpv_pkg::*;

  // Product stage.
  logic [ERR_W:0]           mag;
  logic signed [ERR_W:0]    err_ext;
  logic [GAIN_W-1:0]        pg;
  logic [GAIN_W-1:0]        ig;
  logic signed [ERR_W-1:0]  iv;
  logic signed [PROD_W-1:0] p_nxt;
  logic signed [PROD_W-1:0] i_nxt;
  logic                     zero_nxt;

  logic signed [PROD_W-1:0] p_r;
  logic signed [PROD_W-1:0] i_r;
  logic                     zero_r;
  logic                     fine_r;

  // Rounding and saturation stage.
  logic signed [SUM_W-1:0]  sum;
  logic signed [SUM_W-1:0]  w;
  logic signed [RND_W-1:0]  r;
  logic signed [RND_W-1:0]  lim;
  logic signed [CMD_W-1:0]  cmd_nxt;
  logic signed [CMD_W-1:0]  cmd_r;

  always_comb begin
    err_ext  = {err[ERR_W-1], err};
    mag      = err_ext < 0 ? unsigned'(-err_ext) : unsigned'(err_ext);
    zero_nxt = !ctl.active || (mag <= {2'b00, band});
    pg       = ctl.fine ? fine_gain : coarse_gain;
    ig       = ctl.fine ? fine_igain : '0;
    iv       = ctl.fine ? integ : '0;
    p_nxt    = $signed({1'b0, pg}) * err;
    i_nxt    = $signed({1'b0, ig}) * iv;
  end

  always_ff @(posedge clk) begin
    if (prod_en) begin
      p_r    <= p_nxt;
      i_r    <= i_nxt;
      zero_r <= zero_nxt;
      fine_r <= ctl.fine;
    end
  end

  // Round to nearest with ties upward: add half an LSB, then floor.
  always_comb begin
    sum = {p_r[PROD_W-1], p_r} + {i_r[PROD_W-1], i_r};
    w   = sum + SUM_W'(1 << (FRAC_SHIFT - 1));
    r   = w[SUM_W-1:FRAC_SHIFT];
    lim = $signed({{(RND_W-CMD_W){1'b0}}, (fine_r ? fine_lim : coarse_lim)});
    if (zero_r) begin
      cmd_nxt = '0;
    end else if (kill_small && (r == RND_W'(1) || r == RND_W'(0) || r == -RND_W'(1))) begin
      cmd_nxt = '0;
    end else if (r > lim) begin
      cmd_nxt = lim[CMD_W-1:0];
    end else if (r < -lim) begin
      cmd_nxt = CMD_W'(-lim);
    end else begin
      cmd_nxt = r[CMD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (out_en) begin
      cmd_r <= cmd_nxt;
    end
  end

  assign cmd = cmd_r;

endmodule
